### rtl/core/celg_pkg.sv
// Shared constants, types and elaboration-time log table math for the cross-entropy block.
package celg_pkg;

  localparam int unsigned LOG_TABLE_ENTRIES_DEF = 256;
  localparam int unsigned P_W = 16;
  localparam int unsigned Q_W = 32;
  localparam int unsigned LG_W = 20;
  localparam int unsigned LN_W = 16;
  localparam int unsigned FRAC_W = 15;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W = 5;
  localparam logic [P_W-1:0] ONE_Q15 = 16'h8000;

  typedef struct packed {
    logic load;
    logic step;
  } celg_div_ctrl_t;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = num;
    for (int b = 0; b < 64; b++) begin
      r = {r[63:0], q[63]};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + i/n) in Q16 via 2*atanh(i/(2n+i)), series in Q32, round half up.
  function automatic logic [LN_W-1:0] ln_entry(input int unsigned i, input int unsigned n);
    logic [63:0] den;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] res;
    den = 64'(2 * n + i);
    z = udiv64(64'(i) << 32, den);
    z2 = (z * z) >> 32;
    term = z;
    sum = '0;
    for (int k = 0; k < 20; k++) begin
      sum = sum + udiv64(term, 64'(2 * k + 1));
      term = (term * z2) >> 32;
    end
    res = (2 * sum + 64'd32768) >> 16;
    return res[LN_W-1:0];
  endfunction

endpackage

### rtl/core/celg_if.sv
// Valid/ready channel interfaces for input elements and gradient results.
interface celg_elem_if;
  logic        valid;
  logic        ready;
  logic [15:0] prediction;
  logic [15:0] label;
  logic        last;

  modport source (output valid, prediction, label, last, input ready);
  modport sink (input valid, prediction, label, last, output ready);
endinterface

interface celg_grad_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] prediction_gradient;
  logic        [19:0] label_gradient;
  logic        [31:0] loss;
  logic               loss_final;

  modport source (output valid, prediction_gradient, label_gradient, loss, loss_final,
                  input ready);
  modport sink (input valid, prediction_gradient, label_gradient, loss, loss_final,
                output ready);
endinterface

### rtl/core/celg_div.sv
// Radix-2 restoring divider, one quotient bit per step.
module celg_div (
  input  logic                                clk,
  input  celg_pkg::celg_div_ctrl_t            ctrl,
  input  logic [celg_pkg::Q_W-1:0]            num,
  input  logic [celg_pkg::P_W-1:0]            den,
  output logic [celg_pkg::Q_W-1:0]            quo
);

  logic [celg_pkg::P_W-1:0] rem;
  logic [celg_pkg::P_W-1:0] dv;
  logic [celg_pkg::P_W:0]   trial;
  logic                     fits;

  assign trial = {rem, quo[celg_pkg::Q_W-1]};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= '0;
      quo <= num;
      dv  <= den;
    end else if (ctrl.step) begin
      rem <= fits ? celg_pkg::P_W'(trial - {1'b0, dv}) : trial[celg_pkg::P_W-1:0];
      quo <= {quo[celg_pkg::Q_W-2:0], fits};
    end
  end

endmodule

### rtl/core/celg_log_rom.sv
// Registered-read ROM of ln(1 + i/N) in Q16 for i = 0..N.
module celg_log_rom #(
  parameter int unsigned ENTRIES = celg_pkg::LOG_TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic [$clog2(ENTRIES+1)-1:0]   addr,
  output logic [celg_pkg::LN_W-1:0]      data
);

  typedef logic [celg_pkg::LN_W-1:0] tab_t [0:ENTRIES];

  function automatic tab_t build_tab();
    tab_t t;
    for (int i = 0; i <= int'(ENTRIES); i++) begin
      t[i] = celg_pkg::ln_entry(i, ENTRIES);
    end
    return t;
  endfunction

  localparam tab_t LN_TAB = build_tab();

  always_ff @(posedge clk) begin
    data <= LN_TAB[addr];
  end

endmodule

### rtl/core/cross_entropy_loss_grad.sv
// Cross-entropy element engine: prediction and label gradients plus running loss.
// One element is taken at a time. After a transfer on elem the block is busy while the
// radix-2 divider forms label/prediction one quotient bit per cycle; the log lookup,
// interpolation and loss accumulation run in the steps POS, IDX, LO, INTERP, LG, TERM and SUM.
// The result is loaded into the output register from the HOLD state after the last divider
// step, once any earlier result has been taken on grad, and elem is ready again from that edge.
// A finished result waits in the output register while the next element is computed.
module cross_entropy_loss_grad #(
  parameter int unsigned LOG_TABLE_ENTRIES = celg_pkg::LOG_TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  celg_elem_if.sink     elem,
  celg_grad_if.source   grad
);

  localparam int unsigned AW = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int unsigned PW = celg_pkg::FRAC_W + AW;
  localparam logic [celg_pkg::LN_W-1:0] LN2 =
    celg_pkg::ln_entry(LOG_TABLE_ENTRIES, LOG_TABLE_ENTRIES);

  localparam logic [celg_pkg::CNT_W-1:0] STEP_POS    = 5'd0;
  localparam logic [celg_pkg::CNT_W-1:0] STEP_IDX    = 5'd1;
  localparam logic [celg_pkg::CNT_W-1:0] STEP_LO     = 5'd2;
  localparam logic [celg_pkg::CNT_W-1:0] STEP_INTERP = 5'd3;
  localparam logic [celg_pkg::CNT_W-1:0] STEP_LG     = 5'd4;
  localparam logic [celg_pkg::CNT_W-1:0] STEP_TERM   = 5'd5;
  localparam logic [celg_pkg::CNT_W-1:0] STEP_SUM    = 5'd6;
  localparam logic [celg_pkg::CNT_W-1:0] STEP_LAST   = 5'(celg_pkg::DIV_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BUSY = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic [celg_pkg::CNT_W-1:0] cnt;

  logic [celg_pkg::P_W-1:0] p_c;
  logic [celg_pkg::P_W-1:0] y_c;
  logic [celg_pkg::P_W-1:0] p_norm;
  logic [3:0]               lead;
  logic                     take;
  logic                     load;

  logic [celg_pkg::P_W-1:0]    y_r;
  logic                        last_r;
  logic [celg_pkg::FRAC_W-1:0] f_r;
  logic [3:0]                  sh_r;
  logic [PW-1:0]               pos;
  logic [AW-1:0]               idx;
  logic [AW-1:0]               rom_addr;
  logic [celg_pkg::LN_W-1:0]   rom_q;
  logic [celg_pkg::LN_W-1:0]   lo;
  logic [celg_pkg::LN_W-1:0]   diff;
  logic [30:0]                 ip;
  logic [31:0]                 ip_rnd;
  logic [16:0]                 ln_m;
  logic [celg_pkg::LG_W-1:0]   whole;
  logic [celg_pkg::LG_W-1:0]   lg;
  logic [35:0]                 prod;
  logic [36:0]                 prod_rnd;
  logic [32:0]                 acc_sum;
  logic [31:0]                 loss_next;
  logic [31:0]                 acc;
  logic [celg_pkg::Q_W-1:0]    quo;
  logic                        res_valid;

  celg_pkg::celg_div_ctrl_t div_ctrl;

  always_comb begin
    p_c = elem.prediction;
    if (p_c == '0) begin
      p_c = 16'd1;
    end else if (p_c > celg_pkg::ONE_Q15) begin
      p_c = celg_pkg::ONE_Q15;
    end
    y_c = (elem.label > celg_pkg::ONE_Q15) ? celg_pkg::ONE_Q15 : elem.label;
    lead = '0;
    for (int i = 0; i < 16; i++) begin
      if (p_c[i]) begin
        lead = 4'(i);
      end
    end
    p_norm = p_c << (4'd15 - lead);
  end

  assign take = (state == S_IDLE) && elem.valid;
  assign load = (state == S_HOLD) && (!res_valid || grad.ready);
  assign elem.ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (elem.valid) state_next = S_BUSY;
      end
      S_BUSY: begin
        if (cnt == STEP_LAST) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (take) begin
        cnt <= '0;
      end else if (state == S_BUSY) begin
        cnt <= cnt + 5'd1;
      end
    end
  end

  assign div_ctrl.load = take;
  assign div_ctrl.step = (state == S_BUSY);

  celg_div u_div (
    .clk  (clk),
    .ctrl (div_ctrl),
    .num  ({y_c, 16'd0}),
    .den  (p_c),
    .quo  (quo)
  );

  assign idx      = pos[PW-1:celg_pkg::FRAC_W];
  assign rom_addr = (cnt == STEP_IDX) ? idx : idx + AW'(1);

  celg_log_rom #(
    .ENTRIES (LOG_TABLE_ENTRIES)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  assign diff      = (rom_q >= lo) ? rom_q - lo : '0;
  assign ip_rnd    = 32'(ip) + 32'd16384;
  assign ln_m      = 17'(lo) + ip_rnd[31:15];
  assign whole     = 20'(sh_r) * 20'(LN2);
  assign prod_rnd  = 37'(prod) + 37'd16384;
  assign acc_sum   = 33'(acc) + 33'(prod_rnd[36:15]);

  always_ff @(posedge clk) begin
    if (take) begin
      y_r    <= y_c;
      last_r <= elem.last;
      f_r    <= p_norm[celg_pkg::FRAC_W-1:0];
      sh_r   <= 4'd15 - lead;
    end
    if (state == S_BUSY) begin
      case (cnt)
        STEP_POS:    pos <= PW'(f_r) * PW'(LOG_TABLE_ENTRIES);
        STEP_LO:     lo <= rom_q;
        STEP_INTERP: ip <= 31'(diff) * 31'(pos[celg_pkg::FRAC_W-1:0]);
        STEP_LG:     lg <= (whole >= 20'(ln_m)) ? whole - 20'(ln_m) : '0;
        STEP_TERM:   prod <= 36'(y_r) * 36'(lg);
        STEP_SUM:    loss_next <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        acc       <= last_r ? '0 : loss_next;
        res_valid <= 1'b1;
      end else if (grad.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grad.prediction_gradient <= signed'(32'd0 - quo);
      grad.label_gradient      <= lg;
      grad.loss                <= loss_next;
      grad.loss_final          <= last_r;
    end
  end

  assign grad.valid = res_valid;

endmodule

### rtl/core/celg_checker.sv
// Port-level checks for the cross-entropy block, bound to the top level.
module celg_checker (
  input logic               clk,
  input logic               rst,
  input logic               elem_valid,
  input logic               elem_ready,
  input logic               grad_valid,
  input logic               grad_ready,
  input logic signed [31:0] prediction_gradient,
  input logic        [19:0] label_gradient,
  input logic        [31:0] loss,
  input logic               loss_final
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    grad_valid && !grad_ready |=> grad_valid && $stable(loss) && $stable(loss_final))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    elem_valid && elem_ready |=> !elem_ready)
    else $error("element accepted while busy");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    elem_valid && elem_ready |=> !$rose(grad_valid))
    else $error("result appeared right after accept");

  a_grad_range: assert property (@(posedge clk) disable iff (rst)
    grad_valid |-> (prediction_gradient <= 0) && (label_gradient <= 20'd720896))
    else $error("gradient out of range");

endmodule

bind cross_entropy_loss_grad celg_checker u_celg_checker (
  .clk                 (clk),
  .rst                 (rst),
  .elem_valid          (elem.valid),
  .elem_ready          (elem.ready),
  .grad_valid          (grad.valid),
  .grad_ready          (grad.ready),
  .prediction_gradient (grad.prediction_gradient),
  .label_gradient      (grad.label_gradient),
  .loss                (grad.loss),
  .loss_final          (grad.loss_final)
);

### sim/cross_entropy_loss_grad_test.sv
// Self-checking testbench for the cross-entropy loss and gradient element engine.
`timescale 1ns / 100ps

module cross_entropy_loss_grad_test;

  localparam int unsigned TABLE_N = celg_pkg::LOG_TABLE_ENTRIES_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned RANDOM_PER_PHASE = 312;
  localparam int unsigned STICKY_RUN = 16;
  localparam int unsigned NUM_ROWS = 22;

  typedef struct packed {
    logic signed [31:0] prediction_gradient;
    logic [19:0]        label_gradient;
    logic [31:0]        loss;
    logic               loss_final;
  } grad_item_t;

  typedef struct packed {
    logic [15:0] prediction;
    logic [15:0] label;
    logic        last;
    logic        typed;
    grad_item_t  want;
  } stim_row_t;

  localparam grad_item_t NO_WANT = '{32'sh0, 20'h0, 32'h0, 1'b0};

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{16'h8000, 16'h0000, 1'b1, 1'b1, '{32'sh0, 20'h0, 32'h0, 1'b1}},
    '{16'h8000, 16'h8000, 1'b1, 1'b1, '{32'shFFFF0000, 20'h0, 32'h0, 1'b1}},
    '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '{32'shFFFF0000, 20'h0, 32'h0, 1'b1}},
    '{16'h8000, 16'h0001, 1'b1, 1'b1, '{32'shFFFFFFFE, 20'h0, 32'h0, 1'b1}},
    '{16'h8000, 16'h0000, 1'b0, 1'b1, '{32'sh0, 20'h0, 32'h0, 1'b0}},
    '{16'h0001, 16'h8000, 1'b0, 1'b0, NO_WANT},
    '{16'h0000, 16'h8000, 1'b0, 1'b0, NO_WANT},
    '{16'h0001, 16'h0000, 1'b0, 1'b0, NO_WANT},
    '{16'h4000, 16'h8000, 1'b0, 1'b0, NO_WANT},
    '{16'h0002, 16'h0001, 1'b0, 1'b0, NO_WANT},
    '{16'h0003, 16'h7FFF, 1'b0, 1'b0, NO_WANT},
    '{16'h5555, 16'hAAAA, 1'b0, 1'b0, NO_WANT},
    '{16'hAAAA, 16'h5555, 1'b0, 1'b0, NO_WANT},
    '{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, NO_WANT},
    '{16'd12345, 16'd23456, 1'b1, 1'b0, NO_WANT},
    '{16'h0001, 16'h8000, 1'b1, 1'b0, NO_WANT},
    '{16'h00FF, 16'h0100, 1'b0, 1'b0, NO_WANT},
    '{16'h0101, 16'h8001, 1'b0, 1'b0, NO_WANT},
    '{16'h4001, 16'h3FFF, 1'b0, 1'b0, NO_WANT},
    '{16'h7FFE, 16'h0001, 1'b0, 1'b0, NO_WANT},
    '{16'hFFFF, 16'h0000, 1'b1, 1'b0, NO_WANT},
    '{16'h0000, 16'hFFFF, 1'b1, 1'b0, NO_WANT}
  };

  logic clk = 1'b0;
  logic rst;

  celg_elem_if elem_ch ();
  celg_grad_if grad_ch ();

  cross_entropy_loss_grad #(
    .LOG_TABLE_ENTRIES(TABLE_N)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .elem (elem_ch),
    .grad (grad_ch)
  );

  logic [31:0] ln_q16 [TABLE_N+1];
  logic [31:0] loss_total;
  grad_item_t  expected_grads [$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void build_ln_table();
    logic [63:0] den;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] term;
    logic [63:0] series;
    for (int i = 0; i <= TABLE_N; i++) begin
      den = 64'(2 * TABLE_N + i);
      z = (64'(i) << 32) / den;
      z2 = (z * z) >> 32;
      term = z;
      series = '0;
      for (int k = 0; k < 20; k++) begin
        series = series + term / 64'(2 * k + 1);
        term = (term * z2) >> 32;
      end
      ln_q16[i] = 32'((2 * series + 64'd32768) >> 16);
    end
  endfunction

  function automatic logic [19:0] neg_ln_q16(input logic [15:0] p);
    int unsigned lead;
    logic [15:0] norm;
    int unsigned pos;
    int unsigned idx;
    int unsigned w;
    int unsigned lo;
    int unsigned hi;
    int unsigned ln_m;
    int unsigned whole;
    lead = 0;
    for (int b = 0; b < 16; b++)
      if (p[b]) lead = b;
    norm = p << (15 - lead);
    pos = int'(norm[14:0]) * TABLE_N;
    idx = pos >> 15;
    w = pos & 32'h7FFF;
    lo = ln_q16[idx];
    hi = ln_q16[idx + 1];
    ln_m = lo + (((hi >= lo ? hi - lo : 0) * w + 16384) >> 15);
    whole = (15 - lead) * ln_q16[TABLE_N];
    return 20'(whole >= ln_m ? whole - ln_m : 0);
  endfunction

  function automatic grad_item_t predict_grad(input logic [15:0] p, input logic [15:0] y,
                                              input logic l);
    grad_item_t res;
    logic [15:0] pe;
    logic [15:0] ye;
    logic [63:0] quot;
    logic [63:0] term;
    logic [63:0] sum;
    pe = (p == 16'd0) ? 16'd1 : ((p > celg_pkg::ONE_Q15) ? celg_pkg::ONE_Q15 : p);
    ye = (y > celg_pkg::ONE_Q15) ? celg_pkg::ONE_Q15 : y;
    quot = {32'd0, ye, 16'd0} / {48'd0, pe};
    if (quot > 64'h8000_0000) quot = 64'h8000_0000;
    res.prediction_gradient = 32'd0 - quot[31:0];
    res.label_gradient = neg_ln_q16(pe);
    term = (64'(ye) * 64'(res.label_gradient) + 64'd16384) >> 15;
    sum = 64'(loss_total) + term;
    if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
    res.loss = sum[31:0];
    res.loss_final = l;
    loss_total = l ? 32'd0 : sum[31:0];
    return res;
  endfunction

  task automatic send_element(input logic [15:0] p, input logic [15:0] y, input logic l,
                              input logic typed, input grad_item_t typed_want);
    grad_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      elem_ch.valid <= 1'b0;
      @(posedge clk);
    end
    elem_ch.valid <= 1'b1;
    elem_ch.prediction <= p;
    elem_ch.label <= y;
    elem_ch.last <= l;
    @(posedge clk);
    while (!elem_ch.ready) @(posedge clk);
    predicted = predict_grad(p, y, l);
    expected_grads.push_back(typed ? typed_want : predicted);
  endtask

  function automatic void note_field(input string field, input logic [31:0] want,
                                     input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    grad_item_t want;
    if (grad_ch.valid && grad_ch.ready && !rst) begin
      if (expected_grads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: loss %h", grad_ch.loss);
      end else begin
        want = expected_grads.pop_front();
        note_field("prediction_gradient", want.prediction_gradient,
                   grad_ch.prediction_gradient);
        note_field("label_gradient", 32'(want.label_gradient), 32'(grad_ch.label_gradient));
        note_field("loss", want.loss, grad_ch.loss);
        note_field("loss_final", 32'(want.loss_final), 32'(grad_ch.loss_final));
      end
    end
    grad_ch.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
    if (rst || (elem_ch.valid && elem_ch.ready) || (grad_ch.valid && grad_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [15:0] p;
    logic [15:0] y;
    logic        l;
    int unsigned pick;
    int unsigned e;
    rst = 1'b1;
    elem_ch.valid = 1'b0;
    elem_ch.prediction = '0;
    elem_ch.label = '0;
    elem_ch.last = 1'b0;
    grad_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    quiet_cycles = 0;
    loss_total = '0;
    build_ln_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_element(directed_rows[i].prediction, directed_rows[i].label, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].want);

    // drive a run of the largest loss terms, then clear it
    for (int n = 0; n < STICKY_RUN; n++)
      send_element(16'h0001, celg_pkg::ONE_Q15, n == STICKY_RUN - 1, 1'b0, NO_WANT);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      repeat (RANDOM_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          p = 16'($urandom_range(32768, 1));
        end else if (pick < 75) begin
          e = $urandom_range(15);
          p = 16'(1 << e) | (16'($urandom) & 16'((1 << e) - 1));
        end else if (pick < 85) begin
          case ($urandom_range(4))
            0: p = 16'h0001;
            1: p = 16'h0002;
            2: p = 16'h7FFF;
            3: p = celg_pkg::ONE_Q15;
            default: p = 16'h0000;
          endcase
        end else begin
          p = 16'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 60)      y = 16'($urandom_range(32768, 0));
        else if (pick < 75) y = $urandom_range(1) ? celg_pkg::ONE_Q15 : 16'h0000;
        else if (pick < 85) y = 16'($urandom_range(15));
        else                y = 16'($urandom);
        l = ($urandom_range(7) == 0);
        send_element(p, y, l, 1'b0, NO_WANT);
      end
    end
    elem_ch.valid <= 1'b0;

    while (expected_grads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_grads.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
